/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mscdt_pkg.sv */
// ----------------------------------------------------------------------------
// mscdt_pkg
// Types, codes and defaults of the multi-slot countdown timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mscdt_pkg;

  localparam int DEF_SLOT_COUNT  = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_INVALID   = 3'd1,
    STS_NOSPACE   = 3'd2,
    STS_EXPIRED   = 3'd3,
    STS_CANCELLED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_EXPIRED = 2'd2,
    MODE_CANCEL  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_LAST,
    S_ADD,
    S_SINGLE,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  slot_id;
    logic [15:0] seconds;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  assigned_slot;
    logic [15:0] expired_mask;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;        // latch the beat, clear result, rewind the walk
    logic rd_en;        // tick walk: read current slot count, advance
    logic add_step;     // add walk: test current slot
    logic single_step;  // cancel or release
    logic load_out;     // move result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic add_hit;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/multi_slot_countdown_timer_core.sv */
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_core
// Table of countdown timer slots with tick, add, cancel and release commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | beat
//  in      | in  | in_valid/in_stall  | in_item_t  (command, slot_id, seconds)
//  out     | out | out_valid/out_stall| out_item_t (status, assigned_slot, expired_mask)
//
//  Tick walks the count memory one slot per cycle.
//  Add walks the slot table for the lowest free slot and stops at the first free one.
//  Cancel and release act on the named slot alone.
//  One command at a time; in_stall is high until the result enters the output register.
//  A stalled output holds one result while the next command is accepted.
//  rst is synchronous; all slots come out of reset free, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_countdown_timer_core #(
  parameter int SLOT_COUNT  = mscdt_pkg::DEF_SLOT_COUNT,
  parameter int COUNT_WIDTH = mscdt_pkg::DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mscdt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mscdt_pkg::out_item_t out_data
);
  import mscdt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mscdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mscdt_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/mscdt_ctrl.sv */
// ----------------------------------------------------------------------------
// mscdt_ctrl
// Sequencer for tick, add, cancel and release commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mscdt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  mscdt_pkg::cmd_t       in_cmd,
  output logic                  in_stall,
  input  mscdt_pkg::dp_stat_t   stat,
  output mscdt_pkg::ctrl_cmd_t  cmd
);
  import mscdt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (in_cmd)
            CMD_TICK: state_next = S_TICK;
            CMD_ADD:  state_next = S_ADD;
            default:  state_next = S_SINGLE;
          endcase
        end
      end
      S_TICK: begin
        cmd.rd_en = 1'b1;
        if (stat.idx_last) state_next = S_TICK_LAST;
      end
      // last read is processed here
      S_TICK_LAST: state_next = S_FINISH;
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (stat.add_hit || stat.idx_last) state_next = S_FINISH;
      end
      S_SINGLE: begin
        cmd.single_step = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mscdt_dp.sv */
// ----------------------------------------------------------------------------
// mscdt_dp
// Slot table, count memory, one-slot-per-cycle walk and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mscdt_dp #(
  parameter int SLOT_COUNT  = mscdt_pkg::DEF_SLOT_COUNT,
  parameter int COUNT_WIDTH = mscdt_pkg::DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mscdt_pkg::in_item_t   in_data,
  input  mscdt_pkg::ctrl_cmd_t  cmd,
  output mscdt_pkg::dp_stat_t   stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mscdt_pkg::out_item_t  out_data
);
  import mscdt_pkg::*;

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);
  localparam logic [31:0] SlotCnt  = 32'(SLOT_COUNT);
  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  in_item_t               item;
  logic [IdxW-1:0]        idx;
  mode_t                  mode [SLOT_COUNT];
  logic [COUNT_WIDTH-1:0] mem  [SLOT_COUNT];
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   rd_vld;
  logic [IdxW-1:0]        rd_idx;
  status_t                res_status;
  logic [3:0]             res_slot;
  logic [15:0]            mask;

  logic [IdxW-1:0]        sel_id;
  logic                   id_ok;
  mode_t                  cur_mode;
  status_t                single_sts;
  logic                   add_hit;
  logic [31:0]            secs_w;
  logic [COUNT_WIDTH-1:0] load_val;
  logic                   proc_run;
  logic                   proc_exp;
  logic [3:0]             mbit;
  logic                   we;
  logic [IdxW-1:0]        waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  assign sel_id   = IdxW'(item.slot_id);
  assign id_ok    = 32'(item.slot_id) < SlotCnt;
  assign cur_mode = id_ok ? mode[sel_id] : MODE_FREE;
  assign add_hit  = (mode[idx] == MODE_FREE);
  assign secs_w   = 32'(item.seconds);
  assign load_val = COUNT_WIDTH'((secs_w > CountMax) ? CountMax : secs_w);
  assign proc_run = rd_vld && (mode[rd_idx] == MODE_RUN);
  assign proc_exp = proc_run && (rdata <= COUNT_WIDTH'(1));
  assign mbit     = 4'(rd_idx);

  always_comb begin
    if (item.command == CMD_RELEASE) begin
      single_sts = id_ok ? STS_OK : STS_INVALID;
    end else begin
      unique case (cur_mode)
        MODE_FREE:    single_sts = STS_INVALID;
        MODE_EXPIRED: single_sts = STS_EXPIRED;
        MODE_CANCEL:  single_sts = STS_CANCELLED;
        default:      single_sts = STS_OK;
      endcase
    end
  end

  // single write port: add load or tick decrement, never both
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = load_val;
    if (cmd.add_step && add_hit) begin
      we = 1'b1;
    end else if (proc_run && !proc_exp) begin
      we    = 1'b1;
      waddr = rd_idx;
      wdata = rdata - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) mode[i] <= MODE_FREE;
    end else begin
      if (proc_exp) mode[rd_idx] <= MODE_EXPIRED;
      if (cmd.add_step && add_hit) mode[idx] <= MODE_RUN;
      if (cmd.single_step && id_ok) begin
        if (item.command == CMD_RELEASE) begin
          mode[sel_id] <= MODE_FREE;
        end else if (cur_mode == MODE_RUN) begin
          mode[sel_id] <= MODE_CANCEL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.start) begin
        idx <= '0;
      end else if (cmd.rd_en || (cmd.add_step && !add_hit)) begin
        idx <= idx + IdxW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (cmd.start) begin
      item       <= in_data;
      res_status <= STS_OK;
      res_slot   <= '0;
      mask       <= '0;
    end
    if (cmd.add_step) begin
      if (add_hit) begin
        res_slot <= 4'(idx);
      end else if (idx == LastIdx) begin
        res_status <= STS_NOSPACE;
      end
    end
    // only the low 16 slots have a mask bit
    if (proc_exp && (32'(rd_idx) < 32'd16)) mask[mbit] <= 1'b1;
    if (cmd.single_step) res_status <= single_sts;
    if (cmd.load_out) begin
      out_data.status        <= res_status;
      out_data.assigned_slot <= res_slot;
      out_data.expired_mask  <= mask;
    end
  end

  assign stat.idx_last = (idx == LastIdx);
  assign stat.add_hit  = add_hit;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

/* hw/rtl/mscdt_check.sv */
// ----------------------------------------------------------------------------
// mscdt_check
// Port-level checks of the countdown timer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mscdt_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mscdt_pkg::out_item_t out_data
);
  import mscdt_pkg::*;

  logic accept_in;
  logic hold_out;
  logic out_ok;
  logic slot_zero;
  logic fail_out;
  logic mask_out;

  assign accept_in = in_valid && !in_stall;
  assign hold_out  = out_valid && out_stall;
  assign out_ok    = (out_data.status == STS_OK);
  assign slot_zero = (out_data.assigned_slot == 4'd0);
  assign fail_out  = out_valid && !out_ok;
  assign mask_out  = out_valid && (out_data.expired_mask != 16'd0);

  `ASSERT_CLK(a_out_hold, hold_out |=> out_valid && $stable(out_data), "stalled beat changed")

  // one command in flight: accepting a beat closes the input
  `ASSERT_CLK(a_one_cmd, accept_in |=> in_stall, "input stayed open after accept")

  `ASSERT_CLK(a_fail_slot, fail_out |-> slot_zero, "failed command reports a slot")

  `ASSERT_CLK(a_mask_tick, mask_out |-> out_ok && slot_zero, "expiry mask on a non-tick result")

  `ASSERT_CLK_ALWAYS(a_rst_out, rst |=> !out_valid, "output valid after reset")

endmodule

bind multi_slot_countdown_timer_core mscdt_check u_check (.*);

`default_nettype wire

/* verif/mscdt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mscdt_checker
// Watches both channels of the countdown timer table. Keeps its own copy of
// the slot table, predicts the result of every accepted command and compares
// each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mscdt_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mscdt_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mscdt_pkg::out_item_t out_data,
  output int                   fail_count,
  output int                   pending
);
  import mscdt_pkg::*;

  localparam int SLOTS = DEF_SLOT_COUNT;

  mode_t       slot_state [SLOTS];
  logic [15:0] ticks_left [SLOTS];
  out_item_t   predicted_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one command to the local slot table and returns its result.
  function automatic out_item_t timer_table_step(in_item_t cmd);
    out_item_t res;
    bit        found;
    res        = '0;
    res.status = STS_OK;
    found      = 1'b0;
    case (cmd.command)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state[i] == MODE_RUN) begin
            // a count of zero or one runs out on this tick
            if (ticks_left[i] <= 16'd1) begin
              ticks_left[i]          = '0;
              slot_state[i]          = MODE_EXPIRED;
              res.expired_mask[i]    = 1'b1;
            end else begin
              ticks_left[i] = ticks_left[i] - 16'd1;
            end
          end
        end
      end
      CMD_ADD: begin
        res.status = STS_NOSPACE;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && slot_state[i] == MODE_FREE) begin
            found             = 1'b1;
            slot_state[i]     = MODE_RUN;
            ticks_left[i]     = cmd.seconds;
            res.status        = STS_OK;
            res.assigned_slot = i[3:0];
          end
        end
      end
      CMD_CANCEL: begin
        case (slot_state[cmd.slot_id])
          MODE_FREE:    res.status = STS_INVALID;
          MODE_EXPIRED: res.status = STS_EXPIRED;
          MODE_CANCEL:  res.status = STS_CANCELLED;
          default:      slot_state[cmd.slot_id] = MODE_CANCEL;
        endcase
      end
      default: begin
        slot_state[cmd.slot_id] = MODE_FREE;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = MODE_FREE;
        ticks_left[i] = '0;
      end
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = predicted_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.assigned_slot !== want.assigned_slot)
            report_mismatch($sformatf("assigned_slot got %0d want %0d",
                                      out_data.assigned_slot, want.assigned_slot));
          if (out_data.expired_mask !== want.expired_mask)
            report_mismatch($sformatf("expired_mask got %h want %h",
                                      out_data.expired_mask, want.expired_mask));
        end
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(timer_table_step(in_data));
    end
    pending = predicted_results.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives tick, add, cancel and release commands into the countdown timer
// table: a directed opening over the corner cases, then random traffic under
// four phases of sender idling and receiver stalling. Checking is done by
// mscdt_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mscdt_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int          fail_count;
  int          pending;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multi_slot_countdown_timer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mscdt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Holds the beat until it is taken; returns with valid still high.
  task automatic send_command(cmd_t cmd, logic [3:0] id, logic [15:0] secs);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{command: cmd, slot_id: id, seconds: secs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_command();
    int          pick;
    int          span;
    cmd_t        cmd;
    logic [15:0] secs;
    pick = $urandom_range(0, 99);
    if (pick < 25)      cmd = CMD_TICK;
    else if (pick < 55) cmd = CMD_ADD;
    else if (pick < 73) cmd = CMD_CANCEL;
    else                cmd = CMD_RELEASE;
    // short counts so that slots actually run out between ticks
    span = $urandom_range(0, 9);
    if (span < 6)       secs = 16'($urandom_range(0, 6));
    else if (span < 8)  secs = 16'($urandom_range(0, 40));
    else if (span == 8) secs = 16'($urandom);
    else                secs = {16{1'($urandom_range(0, 1))}};
    send_command(cmd, 4'($urandom_range(0, 15)), secs);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_command(CMD_CANCEL, 4'd5, 16'd0);       // free slot
    send_command(CMD_ADD, 4'd0, 16'd0);          // zero load, slot 0
    send_command(CMD_ADD, 4'd0, 16'hFFFF);       // slot 1
    send_command(CMD_ADD, 4'd0, 16'd1);          // slot 2
    send_command(CMD_CANCEL, 4'd1, 16'd0);
    send_command(CMD_CANCEL, 4'd1, 16'd0);       // already cancelled
    send_command(CMD_TICK, 4'd0, 16'd0);         // slots 0 and 2 run out
    send_command(CMD_CANCEL, 4'd0, 16'd0);       // already expired
    send_command(CMD_RELEASE, 4'd0, 16'd0);
    send_command(CMD_RELEASE, 4'd15, 16'd0);     // release of a free slot
    for (int i = 0; i < 14; i++)
      send_command(CMD_ADD, 4'hF, (i % 2) ? 16'hFFFF : 16'(i));
    send_command(CMD_ADD, 4'd0, 16'd3);          // table full
    send_command(CMD_TICK, 4'hF, 16'hFFFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / PHASE_ITEMS)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 64; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      send_random_command();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
